// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: lbl");
// antecedent this cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/lat1_pkg.sv -----
package lat1_pkg;

   // target_encoding codes
   localparam logic [1:0] ENC_ASCII  = 2'd0;
   localparam logic [1:0] ENC_LATIN1 = 2'd1;
   localparam logic [1:0] ENC_UTF8   = 2'd2;

   localparam logic [7:0] NBSP_CODE  = 8'd160;
   localparam logic [7:0] UNDEF_CHAR = 8'h7a;  // 'z'
   localparam logic [1:0] LEAD_BITS  = 2'b11;  // 0xC0 prefix
   localparam logic [1:0] CONT_BITS  = 2'b10;  // 0x80 prefix

   // ASCII stand-ins for codes 160 to 255
   localparam logic [7:0] TRANSLIT_TABLE [0:95] = '{
      " ", "!", "c", "L", "$", "Y", "|", "P", "\"", "C", "a", "<", ",", "-", "R", "-",
      "d", "+", "2", "3", "'", "u", "P", "*", ",", "1", "o", ">", "4", "2", "3", "?",
      "A", "A", "A", "A", "A", "A", "A", "C", "E", "E", "E", "E", "I", "I", "I", "I",
      "D", "N", "O", "O", "O", "O", "O", "*", "O", "U", "U", "U", "U", "Y", "T", "s",
      "a", "a", "a", "a", "a", "a", "a", "c", "e", "e", "e", "e", "i", "i", "i", "i",
      "d", "n", "o", "o", "o", "o", "o", "/", "o", "u", "u", "u", "u", "y", "t", "y"
   };

   // converted form of one input word
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       two_bytes;
   } conv_type;

endpackage

// ----- rtl/lat1_xlate.sv -----
module lat1_xlate (
   input  logic [7:0]        in_byte,
   input  logic [1:0]        target_encoding,
   output lat1_pkg::conv_type conv
);
   import lat1_pkg::*;

   logic [7:0] offset;
   logic [7:0] ascii_byte;

   // transliteration: pass low half, table for 160 and up, 'z' between
   assign offset = in_byte - NBSP_CODE;

   always_comb begin
      if (!in_byte[7]) begin
         ascii_byte = in_byte;
      end else if (in_byte >= NBSP_CODE) begin
         ascii_byte = TRANSLIT_TABLE[offset[6:0]];
      end else begin
         ascii_byte = UNDEF_CHAR;
      end
   end

   // select by encoding
   always_comb begin
      conv.first_byte  = in_byte;
      conv.second_byte = {CONT_BITS, in_byte[5:0]};
      conv.two_bytes   = 1'b0;
      case (target_encoding)
         ENC_ASCII: begin
            conv.first_byte = ascii_byte;
         end
         ENC_UTF8: begin
            if (in_byte[7]) begin
               conv.first_byte = {LEAD_BITS, 4'b0000, in_byte[7:6]};
               conv.two_bytes  = 1'b1;
            end
         end
         default: begin
            conv.first_byte = in_byte;
         end
      endcase
   end

endmodule

// ----- rtl/lat1_out.sv -----
`include "assert_macros.svh"

module lat1_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lat1_pkg::conv_type conv,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);
   import lat1_pkg::*;

   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       load;
   logic       take;

   // new word may enter once the current byte leaves with nothing behind it
   assign take     = valid_ff && rsp_ready;
   assign in_ready = !valid_ff || (rsp_ready && !pend_ff);
   assign load     = in_valid && in_ready;

   // next result word
   always_comb begin
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      pend_byte_in = pend_byte_ff;
      if (load) begin
         valid_in     = 1'b1;
         byte_in      = conv.first_byte;
         last_in      = !conv.two_bytes;
         pend_in      = conv.two_bytes;
         pend_byte_in = conv.second_byte;
      end else if (take && pend_ff) begin
         byte_in  = pend_byte_ff;
         last_in  = 1'b1;
         pend_in  = 1'b0;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      pend_byte_ff <= pend_byte_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

   // a pending second byte always sits behind a shown first byte
   `ASSERT_HOLDS(a_pend_shown, clock, reset, !pend_ff || (valid_ff && !last_ff))
   // second byte follows the first directly, marked last
   `ASSERT_NEXT(a_second_next, clock, reset, take && pend_ff, valid_ff && last_ff)
   // no new word overwrites a pending pair
   `ASSERT_HOLDS(a_no_overrun, clock, reset, !(load && pend_ff))

endmodule

// ----- rtl/latin1_charset_converter.sv -----
// Latin-1 to ASCII / Latin-1 / UTF-8 converter.
// Path: a word accepted on req passes the input register and then the result register to rsp.
// Throughput: one input word per cycle while rsp_ready is high; UTF-8 codes 128..255 give two
// rsp words, and no new word enters the result register until the pending second byte has left.
// Reset (synchronous, active high) empties both stages and sets the encoding to ASCII.
module latin1_charset_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);
   import lat1_pkg::*;

   logic [1:0] target_encoding_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       stage_ready;
   conv_type   conv;

   // encoding register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_encoding_ff <= ENC_ASCII;
      end else if (csr_wr_en) begin
         target_encoding_ff <= csr_wr_data;
      end
   end

   // input register
   assign req_ready = !in_valid_ff || stage_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   lat1_xlate u_xlate (
      .in_byte         (in_byte_ff),
      .target_encoding (target_encoding_ff),
      .conv            (conv)
   );

   lat1_out u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .in_ready     (stage_ready),
      .conv         (conv),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
